>>> rtl/core/ubxfr_pkg.sv
// ----------------------------------------------------------------------------
// ubxfr_pkg
// Shared constants and types for the frame receiver: sync bytes, result
// kinds, parser phases, the length width and the default length limit.
// ----------------------------------------------------------------------------
package ubxfr_pkg;

	localparam logic [7:0]  SYNC_FIRST       = 8'hB5;
	localparam logic [7:0]  SYNC_SECOND      = 8'h62;
	localparam int          LEN_W            = 16;
	localparam logic [15:0] MAX_LENGTH_RESET = 16'd100;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_GOOD = 2'd1,
		KIND_BAD  = 2'd2
	} kind_t;

	typedef enum logic [8:0] {
		PH_HUNT   = 9'b000000001,
		PH_SYNC2  = 9'b000000010,
		PH_CLASS  = 9'b000000100,
		PH_ID     = 9'b000001000,
		PH_LEN_LO = 9'b000010000,
		PH_LEN_HI = 9'b000100000,
		PH_DATA   = 9'b001000000,
		PH_CK_A   = 9'b010000000,
		PH_CK_B   = 9'b100000000
	} phase_t;

endpackage

>>> rtl/core/ubx_frame_receiver.sv
// flow: an accepted input word goes from the input register through the
//   combinational parse step into the result register; one input word per
//   cycle while the result register is empty or being read (out_ready)
// reset: arst_n clears the parser to hunting, sums and counters to zero,
//   max_length to 100, and drops any word held in either register
// ----------------------------------------------------------------------------
// ubx_frame_receiver
// Byte-wise frame parser: sync hunt, header, payload words with index and a
// frame-end word with the Fletcher-8 checksum verdict.
// ----------------------------------------------------------------------------
module ubx_frame_receiver (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [ubxfr_pkg::LEN_W-1:0]    cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     rx_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     kind,
	output logic [7:0]                     payload_byte,
	output logic [ubxfr_pkg::LEN_W-1:0]    byte_index,
	output logic [7:0]                     msg_class,
	output logic [7:0]                     msg_id,
	output logic [ubxfr_pkg::LEN_W-1:0]    msg_length
);
	import ubxfr_pkg::*;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             advance;

	logic [LEN_W-1:0] max_length_q;
	phase_t           phase_q,   phase_d;
	logic [7:0]       class_q,   class_d;
	logic [7:0]       id_q,      id_d;
	logic [LEN_W-1:0] length_q,  length_d;
	logic [LEN_W-1:0] count_q,   count_d;
	logic [7:0]       sum_a_q,   sum_a_d;
	logic [7:0]       sum_b_q,   sum_b_d;
	logic [7:0]       rx_ck_a_q, rx_ck_a_d;

	logic             res_valid;
	kind_t            res_kind;
	logic [7:0]       res_byte;
	logic [LEN_W-1:0] res_index;

	logic             out_valid_q;
	kind_t            kind_q;
	logic [7:0]       payload_byte_q;
	logic [LEN_W-1:0] byte_index_q;
	logic [7:0]       msg_class_q;
	logic [7:0]       msg_id_q;
	logic [LEN_W-1:0] msg_length_q;

	logic [7:0]       add_a;
	logic [7:0]       add_b;
	logic [LEN_W-1:0] count_inc;
	logic [LEN_W-1:0] len_full;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LENGTH_RESET;
		end else if (cfg_wen) begin
			max_length_q <= cfg_wdata;
		end
	end

	// running checksum, restarted at the class byte
	always_comb begin
		add_a = ((phase_q == PH_CLASS) ? 8'd0 : sum_a_q) + byte_s1;
		add_b = ((phase_q == PH_CLASS) ? 8'd0 : sum_b_q) + add_a;
	end

	assign count_inc = count_q + 1'b1;
	assign len_full  = {byte_s1, length_q[7:0]};

	always_comb begin
		phase_d   = phase_q;
		class_d   = class_q;
		id_d      = id_q;
		length_d  = length_q;
		count_d   = count_q;
		sum_a_d   = sum_a_q;
		sum_b_d   = sum_b_q;
		rx_ck_a_d = rx_ck_a_q;
		res_valid = 1'b0;
		res_kind  = KIND_DATA;
		res_byte  = 8'd0;
		res_index = '0;
		unique case (phase_q)
			PH_SYNC2: begin
				if (byte_s1 == SYNC_SECOND) begin
					phase_d = PH_CLASS;
				end else if (byte_s1 != SYNC_FIRST) begin
					phase_d = PH_HUNT;
				end
			end
			PH_CLASS: begin
				sum_a_d = add_a;
				sum_b_d = add_b;
				class_d = byte_s1;
				phase_d = PH_ID;
			end
			PH_ID: begin
				sum_a_d = add_a;
				sum_b_d = add_b;
				id_d    = byte_s1;
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				sum_a_d  = add_a;
				sum_b_d  = add_b;
				length_d = {{(LEN_W-8){1'b0}}, byte_s1};
				phase_d  = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				sum_a_d  = add_a;
				sum_b_d  = add_b;
				length_d = len_full;
				count_d  = '0;
				priority if (len_full > max_length_q) begin
					phase_d = PH_HUNT;
				end else if (len_full == '0) begin
					phase_d = PH_CK_A;
				end else begin
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				sum_a_d   = add_a;
				sum_b_d   = add_b;
				res_valid = 1'b1;
				res_kind  = KIND_DATA;
				res_byte  = byte_s1;
				res_index = count_q;
				count_d   = count_inc;
				if (count_inc >= length_q) begin
					phase_d = PH_CK_A;
				end
			end
			PH_CK_A: begin
				rx_ck_a_d = byte_s1;
				phase_d   = PH_CK_B;
			end
			PH_CK_B: begin
				res_valid = 1'b1;
				res_kind  = ((rx_ck_a_q == sum_a_q) && (byte_s1 == sum_b_q)) ?
					KIND_GOOD : KIND_BAD;
				phase_d   = PH_HUNT;
			end
			default: begin
				phase_d = (byte_s1 == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
			end
		endcase
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			class_q   <= 8'd0;
			id_q      <= 8'd0;
			length_q  <= '0;
			count_q   <= '0;
			sum_a_q   <= 8'd0;
			sum_b_q   <= 8'd0;
			rx_ck_a_q <= 8'd0;
		end else if (advance) begin
			phase_q   <= phase_d;
			class_q   <= class_d;
			id_q      <= id_d;
			length_q  <= length_d;
			count_q   <= count_d;
			sum_a_q   <= sum_a_d;
			sum_b_q   <= sum_b_d;
			rx_ck_a_q <= rx_ck_a_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			kind_q         <= res_kind;
			payload_byte_q <= res_byte;
			byte_index_q   <= res_index;
			msg_class_q    <= class_q;
			msg_id_q       <= id_q;
			msg_length_q   <= length_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign payload_byte = payload_byte_q;
	assign byte_index   = byte_index_q;
	assign msg_class    = msg_class_q;
	assign msg_id       = msg_id_q;
	assign msg_length   = msg_length_q;

	// checks
	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q))
		else $error("parser phase not one-hot");

	a_index_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == KIND_DATA |-> byte_index_q < msg_length_q)
		else $error("payload index beyond frame length");

	a_end_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (kind_q == KIND_GOOD || kind_q == KIND_BAD)
		|-> payload_byte_q == 8'd0 && byte_index_q == '0)
		else $error("frame-end word carries payload fields");

	a_data_in_payload: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_valid && res_kind == KIND_DATA |=> phase_q == PH_DATA
		|| phase_q == PH_CK_A)
		else $error("payload word outside payload phase");

endmodule

>>> sim/tb_ubx_frame_receiver.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ubx_frame_receiver
// Self-checking bench for the frame receiver. A clocked driver feeds a stream
// of received bytes (clean frames, truncated frames, oversize headers, line
// noise), a parse model predicts every payload and frame-end word, and a
// clocked monitor compares each word field by field. Runs under several
// max_length settings with random idling on both handshakes.
// ----------------------------------------------------------------------------
module tb_ubx_frame_receiver;
	import ubxfr_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 4;

	typedef struct {
		kind_t       kind;
		logic [7:0]  pbyte;
		logic [15:0] index;
		logic [7:0]  cls;
		logic [7:0]  id;
		logic [15:0] len;
	} frame_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wen = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  payload_byte;
	logic [15:0] byte_index;
	logic [7:0]  msg_class;
	logic [7:0]  msg_id;
	logic [15:0] msg_length;

	logic [7:0]  rx_stream[$];
	frame_word_t parsed_words[$];
	frame_word_t seen;

	// parse model state
	phase_t      st = PH_HUNT;
	logic [7:0]  hdr_class = '0;
	logic [7:0]  hdr_id = '0;
	logic [15:0] hdr_len = '0;
	logic [15:0] pay_cnt = '0;
	logic [7:0]  run_a = '0;
	logic [7:0]  run_b = '0;
	logic [7:0]  ck_a_rx = '0;
	logic [15:0] len_limit = MAX_LENGTH_RESET;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int err_count = 0;
	int stall_cycles = 0;
	int n_bytes = 0;
	int n_payload = 0;
	int n_good = 0;
	int n_bad = 0;

	ubx_frame_receiver DUT (
		.clk, .arst_n, .cfg_wen, .cfg_wdata,
		.in_valid, .in_ready, .rx_byte,
		.out_valid, .out_ready, .kind, .payload_byte, .byte_index,
		.msg_class, .msg_id, .msg_length
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	task automatic flag_mismatch(input string msg);
		err_count++;
		if (err_count <= 30) $display("mismatch: %s", msg);
	endtask

	task automatic push_word(input kind_t k, input logic [7:0] b, input logic [15:0] idx);
		frame_word_t w;
		w.kind = k;
		w.pbyte = b;
		w.index = idx;
		w.cls = hdr_class;
		w.id = hdr_id;
		w.len = hdr_len;
		parsed_words.push_back(w);
	endtask

	task automatic parse_rx_byte(input logic [7:0] b);
		if (st inside {PH_CLASS, PH_ID, PH_LEN_LO, PH_LEN_HI, PH_DATA}) begin
			if (st == PH_CLASS) begin
				run_a = '0;
				run_b = '0;
			end
			run_a = run_a + b;
			run_b = run_b + run_a;
		end
		case (st)
			PH_SYNC2: begin
				if (b == SYNC_SECOND) st = PH_CLASS;
				else if (b != SYNC_FIRST) st = PH_HUNT;
			end
			PH_CLASS: begin
				hdr_class = b;
				st = PH_ID;
			end
			PH_ID: begin
				hdr_id = b;
				st = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				hdr_len = {8'h00, b};
				st = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				hdr_len[15:8] = b;
				pay_cnt = '0;
				if (hdr_len > len_limit) st = PH_HUNT;
				else if (hdr_len == 0) st = PH_CK_A;
				else st = PH_DATA;
			end
			PH_DATA: begin
				push_word(KIND_DATA, b, pay_cnt);
				n_payload++;
				pay_cnt = pay_cnt + 1'b1;
				if (pay_cnt >= hdr_len) st = PH_CK_A;
			end
			PH_CK_A: begin
				ck_a_rx = b;
				st = PH_CK_B;
			end
			PH_CK_B: begin
				if (ck_a_rx == run_a && b == run_b) begin
					push_word(KIND_GOOD, 8'h00, 16'h0000);
					n_good++;
				end else begin
					push_word(KIND_BAD, 8'h00, 16'h0000);
					n_bad++;
				end
				st = PH_HUNT;
			end
			default: st = (b == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
		endcase
	endtask

	// sync, header, payload and checksum; cut > 0 keeps only that many bytes
	task automatic queue_frame(input logic [7:0] cls, input logic [7:0] id, input int len,
			input bit spoil, input int cut);
		logic [7:0] f[$];
		logic [7:0] ca;
		logic [7:0] cb;
		int keep;
		f = {SYNC_FIRST, SYNC_SECOND, cls, id, len[7:0], len[15:8]};
		for (int i = 0; i < len && (cut == 0 || f.size() < cut); i++)
			f.push_back(8'($urandom_range(0, 255)));
		ca = '0;
		cb = '0;
		for (int i = 2; i < f.size(); i++) begin
			ca = ca + f[i];
			cb = cb + ca;
		end
		if (spoil) begin
			if ($urandom_range(0, 1)) ca = ca ^ 8'($urandom_range(1, 255));
			else cb = cb ^ 8'($urandom_range(1, 255));
		end
		f.push_back(ca);
		f.push_back(cb);
		keep = (cut > 0 && cut < f.size()) ? cut : f.size();
		for (int i = 0; i < keep; i++) rx_stream.push_back(f[i]);
	endtask

	task automatic wait_drained();
		while (rx_stream.size() != 0 || in_valid || parsed_words.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			st = PH_HUNT;
			hdr_class = '0;
			hdr_id = '0;
			hdr_len = '0;
			pay_cnt = '0;
			run_a = '0;
			run_b = '0;
			ck_a_rx = '0;
			len_limit = MAX_LENGTH_RESET;
		end else begin
			if (in_valid && in_ready) begin
				parse_rx_byte(rx_byte);
				n_bytes++;
			end
			if (!in_valid || in_ready) begin
				if (rx_stream.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					rx_byte <= rx_stream.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (parsed_words.size() == 0) begin
					flag_mismatch($sformatf("unexpected word kind %0d", kind));
				end else begin
					seen = parsed_words.pop_front();
					if (kind !== seen.kind)
						flag_mismatch($sformatf("kind %0d, want %0d", kind, seen.kind));
					if (payload_byte !== seen.pbyte)
						flag_mismatch($sformatf("payload_byte %h, want %h", payload_byte,
							seen.pbyte));
					if (byte_index !== seen.index)
						flag_mismatch($sformatf("byte_index %0d, want %0d", byte_index,
							seen.index));
					if (msg_class !== seen.cls)
						flag_mismatch($sformatf("msg_class %h, want %h", msg_class, seen.cls));
					if (msg_id !== seen.id)
						flag_mismatch($sformatf("msg_id %h, want %h", msg_id, seen.id));
					if (msg_length !== seen.len)
						flag_mismatch($sformatf("msg_length %0d, want %0d", msg_length,
							seen.len));
				end
			end
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else if (rx_stream.size() != 0 || in_valid || parsed_words.size() != 0)
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: no word moved in %0d cycles", STALL_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		int lim;
		int cap;
		int len;
		int r;
		int target;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset limit, no idling
		rx_stream.push_back(8'h00);
		rx_stream.push_back(8'hFF);
		rx_stream.push_back(SYNC_FIRST);
		queue_frame(8'h00, 8'hFF, 0, 1'b0, 0);
		rx_stream.push_back(SYNC_FIRST);
		rx_stream.push_back(8'h00);
		queue_frame(8'hFF, 8'h00, 2, 1'b1, 0);
		queue_frame(8'h5A, 8'hA5, 16'hFFFF, 1'b0, 6);
		queue_frame(8'h01, 8'h02, 1, 1'b0, 0);

		for (int p = 0; p < 8; p++) begin
			wait_drained();
			case (p)
				0: lim = 0;
				1: lim = 3;
				2: lim = 20;
				3: lim = 65535;
				4: lim = $urandom_range(1, 40);
				5: lim = 100;
				6: lim = 1;
				default: lim = $urandom_range(5, 60);
			endcase
			@(posedge clk);
			cfg_wen <= 1'b1;
			cfg_wdata <= lim[15:0];
			len_limit = lim[15:0];
			@(posedge clk);
			cfg_wen <= 1'b0;
			case (p % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 58; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 58; end
				default: begin send_idle_pct = 32; recv_stall_pct = 32; end
			endcase
			cap = (lim < 16) ? lim + 2 : 16;
			if (lim == 65535) queue_frame(8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 300, 1'b0, 0);
			target = 50;
			while (rx_stream.size() < target) begin
				r = $urandom_range(0, 99);
				len = $urandom_range(0, cap);
				if (r < 60) begin
					if ($urandom_range(0, 4) == 0) rx_stream.push_back(SYNC_FIRST);
					queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len,
						$urandom_range(0, 99) < 12, 0);
				end else if (r < 72) begin
					repeat ($urandom_range(1, 4))
						rx_stream.push_back($urandom_range(0, 3) == 0 ? SYNC_FIRST :
							8'($urandom_range(0, 255)));
				end else if (r < 84) begin
					queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len,
						1'b0, $urandom_range(1, len + 7));
				end else if (r < 94 && lim < 65535) begin
					queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						$urandom_range(lim + 1, 65535), 1'b0, 6);
				end else begin
					rx_stream.push_back(SYNC_FIRST);
					rx_stream.push_back(8'($urandom_range(0, 255)));
				end
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (parsed_words.size() != 0)
			flag_mismatch($sformatf("%0d words never arrived", parsed_words.size()));
		$display("run covered %0d input bytes over 9 length limits with mixed idling",
			n_bytes);
		$display("checked %0d payload words, %0d good and %0d bad frame ends",
			n_payload, n_good, n_bad);
		if (err_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> files.f
rtl/core/ubxfr_pkg.sv
rtl/core/ubx_frame_receiver.sv
sim/tb_ubx_frame_receiver.sv
